### hdl/sau_pkg.sv
// Package for the stack arithmetic unit: sizes, codes, item structs and FSM states.
// Depends on nothing; sau_div and stack_arithmetic_unit import it.
package sau_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int DIV_CNT_W   = $clog2(WORD_W + 1);
  localparam int CHAR_MAX    = 127;
  localparam int MIN_BINARY  = 2;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_SUB   = 3'd1,
    ACT_DIV   = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_MOD   = 3'd4,
    ACT_PCHAR = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_RANGE   = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [WORD_W-1:0]   push_value;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [WORD_W-1:0]   top_value;
    logic                       char_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB
  } fsm_t;

endpackage

### hdl/sau_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the stack store.
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sau_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sau_pkg for the word width and counter width.
module sau_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [sau_pkg::WORD_W-1:0]    dividend,
  input  logic signed [sau_pkg::WORD_W-1:0]    divisor,
  output logic                                 done,
  output logic signed [sau_pkg::WORD_W-1:0]    quotient,
  output logic signed [sau_pkg::WORD_W-1:0]    remainder
);
  import sau_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] count;
  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dmag;
  logic                 neg_q;
  logic                 neg_r;
  logic [WORD_W:0]      trial;

  // Trial subtract of the magnitude divisor from the shifted partial remainder.
  assign trial = {rem, quo[WORD_W-1]} - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= DIV_CNT_W'(WORD_W);
        quo     <= dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
        dmag    <= divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
        rem     <= '0;
        neg_q   <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        neg_r   <= dividend[WORD_W-1];
      end else if (running) begin
        if (!trial[WORD_W]) begin
          rem <= trial[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b1};
        end else begin
          rem <= {rem[WORD_W-2:0], quo[WORD_W-1]};
          quo <= {quo[WORD_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Restore signs: quotient by sign difference, remainder follows the dividend.
  assign quotient  = neg_q ? WORD_W'(-quo) : quo;
  assign remainder = neg_r ? WORD_W'(-rem) : rem;

endmodule

### hdl/stack_arithmetic_unit.sv
// Stack arithmetic unit top level: FSM, top-of-stack cache, ALU and result register.
// Depends on sau_pkg, sau_ram (stack store) and sau_div (divide/modulo unit).
//
//  channel   | ports                     | handshake
//  ----------+---------------------------+---------------------------------------
//  command   | request (in_item_t)       | taken when start is high and busy low
//  result    | result (out_item_t)       | valid for one cycle while done is high
//
// Push, pchar, unused codes and every error: result in the cycle after the item,
// busy stays low, so a new item can follow at once.
// Sub and mul: stack read and compute (S_READ), then write back (S_WB).
// Div and mod: stack read, divider retiring one quotient bit a cycle, write back.
// Reset clears depth and the done strobe; the store needs no clearing since only
// entries below depth are ever read. The receiver cannot stall: done is a pulse.
module stack_arithmetic_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sau_pkg::in_item_t   request,
  output logic                busy,
  output logic                done,
  output sau_pkg::out_item_t  result
);
  import sau_pkg::*;

  fsm_t                     state;
  fsm_t                     state_next;
  action_t                  act;
  logic [DEPTH_W-1:0]       depth;
  logic signed [WORD_W-1:0] top;
  logic signed [WORD_W-1:0] res;
  logic signed [WORD_W-1:0] top_out;
  logic [PTR_W-1:0]         second_idx;

  logic                     ram_we;
  logic [PTR_W-1:0]         ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic [PTR_W-1:0]         ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic signed [WORD_W-1:0] second;

  logic                     div_start;
  logic                     div_done;
  logic signed [WORD_W-1:0] div_quo;
  logic signed [WORD_W-1:0] div_rem;

  // The top word lives in a register as well as in the store, so only the
  // second word ever has to be read. A push writes entry depth while the read
  // port is on depth-2; write back writes the entry being read, whose data is unused.
  sau_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (second),
    .divisor   (top),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign second     = ram_rdata;
  assign second_idx = PTR_W'(depth - DEPTH_W'(MIN_BINARY));
  assign top_out    = (depth == '0) ? '0 : top;
  assign busy       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state plus store and divider controls.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = depth[PTR_W-1:0];
    ram_wdata  = request.push_value;
    ram_raddr  = second_idx;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (request.action)
            ACT_PUSH: begin
              if (depth != DEPTH_W'(STACK_DEPTH)) begin
                ram_we = 1'b1;
              end
            end
            ACT_SUB, ACT_MUL: begin
              if (depth >= DEPTH_W'(MIN_BINARY)) begin
                state_next = S_READ;
              end
            end
            ACT_DIV, ACT_MOD: begin
              if (depth >= DEPTH_W'(MIN_BINARY) && top != '0) begin
                state_next = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // Second word is on the read port now.
        if (act inside {ACT_DIV, ACT_MOD}) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_WB;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        // Replace the second word and drop the top.
        ram_we     = 1'b1;
        ram_waddr  = second_idx;
        ram_wdata  = res;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Depth, top cache and the done strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (request.action)
              ACT_PUSH: begin
                if (depth != DEPTH_W'(STACK_DEPTH)) begin
                  depth <= depth + 1'b1;
                  top   <= request.push_value;
                end
                done <= 1'b1;
              end
              ACT_SUB, ACT_MUL: begin
                done <= (depth < DEPTH_W'(MIN_BINARY));
              end
              ACT_DIV, ACT_MOD: begin
                done <= (depth < DEPTH_W'(MIN_BINARY)) || (top == '0);
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WB: begin
          depth <= depth - 1'b1;
          top   <= res;
          done  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: latched action, ALU result and the outgoing item.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          act               <= request.action;
          result.top_value  <= top_out;
          result.char_valid <= 1'b0;
          result.status     <= ST_OK;
          case (request.action)
            ACT_PUSH: begin
              if (depth == DEPTH_W'(STACK_DEPTH)) begin
                result.status <= ST_FULL;
              end else begin
                result.top_value <= request.push_value;
              end
            end
            ACT_SUB, ACT_MUL: begin
              result.status <= ST_SHORT;
            end
            ACT_DIV, ACT_MOD: begin
              // Too short takes precedence over divide by zero.
              if (depth < DEPTH_W'(MIN_BINARY)) begin
                result.status <= ST_SHORT;
              end else begin
                result.status <= ST_DIVZERO;
              end
            end
            ACT_PCHAR: begin
              if (depth == '0) begin
                result.status <= ST_EMPTY;
              end else if ($unsigned(top) <= WORD_W'(CHAR_MAX)) begin
                result.char_valid <= 1'b1;
              end else begin
                result.status <= ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (act == ACT_SUB) begin
          res <= WORD_W'(second - top);
        end else begin
          // Low word of the product; sign does not affect it.
          res <= WORD_W'(second * top);
        end
      end
      S_DIV: begin
        if (div_done) begin
          res <= (act == ACT_DIV) ? div_quo : div_rem;
        end
      end
      S_WB: begin
        result.status     <= ST_OK;
        result.top_value  <= res;
        result.char_valid <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule
